// ===== hw/rtl/nor_seq_pkg.sv =====
// ----------------------------------------------------------------------------
// nor_seq_pkg
// Shared types and codes of the SPI NOR flash command sequencer: item kinds,
// operation codes, flash opcodes, the one-hot phase type and the result item.
// ----------------------------------------------------------------------------
package nor_seq_pkg;

  // item kinds on the input channel
  localparam logic [1:0] KIND_REQ  = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_DATA = 2'd2;

  // request operation codes
  localparam logic [2:0] OP_READ    = 3'd0;
  localparam logic [2:0] OP_WRITE   = 3'd1;
  localparam logic [2:0] OP_SECTOR  = 3'd2;
  localparam logic [2:0] OP_BULK    = 3'd3;
  localparam logic [2:0] OP_READ_ID = 3'd4;
  localparam logic [2:0] OP_PDOWN   = 3'd5;
  localparam logic [2:0] OP_RELEASE = 3'd6;
  localparam logic [2:0] OP_INVALID = 3'd7;

  // flash opcodes and filler
  localparam logic [7:0] CMD_PROGRAM = 8'h02;
  localparam logic [7:0] CMD_WREN    = 8'h06;
  localparam logic [7:0] CMD_READ    = 8'h03;
  localparam logic [7:0] CMD_STATUS  = 8'h05;
  localparam logic [7:0] CMD_ID      = 8'h9F;
  localparam logic [7:0] CMD_SECTOR  = 8'h20;
  localparam logic [7:0] CMD_BULK    = 8'hC7;
  localparam logic [7:0] CMD_SLEEP   = 8'hB9;
  localparam logic [7:0] CMD_WAKE    = 8'hAB;
  localparam logic [7:0] FILLER      = 8'hA5;

  // status register busy flag position
  localparam int unsigned BUSY_BIT = 0;

  // last address byte index
  localparam logic [1:0] ADDR_IDX_LAST = 2'd2;

  // sequencer phases, one-hot
  typedef enum logic [12:0] {
    PH_IDLE       = 13'b0_0000_0000_0001,
    PH_WREN       = 13'b0_0000_0000_0010,
    PH_OPC        = 13'b0_0000_0000_0100,
    PH_ADDR       = 13'b0_0000_0000_1000,
    PH_DATA_WAIT  = 13'b0_0000_0001_0000,
    PH_DATA_SENT  = 13'b0_0000_0010_0000,
    PH_READ_SENT  = 13'b0_0000_0100_0000,
    PH_STAT_OP    = 13'b0_0000_1000_0000,
    PH_POLL       = 13'b0_0001_0000_0000,
    PH_ID_OP      = 13'b0_0010_0000_0000,
    PH_ID_SENT    = 13'b0_0100_0000_0000,
    PH_FINAL      = 13'b0_1000_0000_0000,
    PH_ERASE_SENT = 13'b1_0000_0000_0000
  } phase_t;

  // one result item
  typedef struct packed {
    logic       send;
    logic [7:0] mosi_byte;
    logic       end_frame;
    logic       need_data;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       done_res;
    logic       rejected;
  } res_t;

endpackage

// ===== hw/rtl/spi_nor_flash_command_sequencer.sv =====
// ----------------------------------------------------------------------------
// spi_nor_flash_command_sequencer
// Sequences SPI NOR flash commands one byte transfer per result item, splits
// writes at page boundaries and polls status until the flash is not busy.
// ----------------------------------------------------------------------------
// Each input item (a request, a completed byte transfer or a host data byte)
// yields exactly one result item. An item passes through an input register
// and then a result register, where its result is presented; one item is
// accepted every clock while the result side keeps up. The sustained rate of
// one item per cycle is set by the single pass of the phase logic between
// the two registers; the page offset of a request address is formed by a
// reciprocal multiply ahead of the input register and a constant multiply
// and correction behind it. A result that is not taken holds the result
// register and then the input register stalls.
module spi_nor_flash_command_sequencer
  import nor_seq_pkg::*;
#(
  parameter int unsigned PAGE_SIZE = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  // request and event items
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [2:0]  in_operation,
  input  logic [23:0] in_address,
  input  logic [15:0] in_length,
  input  logic [7:0]  in_miso_byte,
  input  logic [7:0]  in_write_byte,
  // result items
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_send,
  output logic [7:0]  out_mosi_byte,
  output logic        out_end_frame,
  output logic        out_need_data,
  output logic        out_read_valid,
  output logic [7:0]  out_read_byte,
  output logic        out_done_res,
  output logic        out_rejected
);

  // page geometry derived from the page size
  localparam int unsigned OFF_W    = $clog2(PAGE_SIZE);
  localparam int unsigned PG_LOG   = $clog2(PAGE_SIZE + 1) - 1;
  localparam int unsigned Q_W      = 24 - PG_LOG;
  localparam int unsigned RECIP_W  = 33 - PG_LOG;
  localparam logic [63:0] RECIP64  = (64'd1 << 32) / PAGE_SIZE;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP64);
  localparam logic [23:0] PAGE24   = 24'(PAGE_SIZE);
  localparam logic [OFF_W:0] PAGE_REM = (OFF_W + 1)'(PAGE_SIZE);
  localparam logic [OFF_W-1:0] OFF_LAST = OFF_W'(PAGE_SIZE - 1);
  localparam logic [8:0] PAGE9     = 9'(PAGE_SIZE);
  localparam logic [23:0] ADDR_MAX = 24'hFF_FFFF;

  // handshake
  logic s1_valid_r;
  logic out_valid_r;
  logic out_free;
  logic in_take;
  logic advance;

  // input register
  logic [1:0]     s1_kind_r;
  logic [2:0]     s1_operation_r;
  logic [23:0]    s1_address_r;
  logic [15:0]    s1_length_r;
  logic [7:0]     s1_miso_byte_r;
  logic [7:0]     s1_write_byte_r;
  logic [Q_W-1:0] s1_quot_r;
  logic [24+RECIP_W-1:0] recip_prod;

  // sequencer state
  phase_t          phase_r, phase_nxt;
  logic [2:0]      cur_op_r, cur_op_nxt;
  logic [23:0]     next_addr_r, next_addr_nxt;
  logic [15:0]     bytes_rem_r, bytes_rem_nxt;
  logic [8:0]      chunk_rem_r, chunk_rem_nxt;
  logic [1:0]      addr_idx_r, addr_idx_nxt;
  logic [OFF_W-1:0] page_off_r, page_off_nxt;

  // result register
  res_t out_res_r, res_nxt;

  // page offset of the request address
  logic [23:0]      quot_base;
  logic [23:0]      rem_raw;
  logic [OFF_W:0]   rem_lo;
  logic [OFF_W-1:0] req_off;

  // helpers for the phase logic
  logic [OFF_W-1:0] chunk_off;
  logic [15:0]      chunk_bytes;
  logic [8:0]       room;
  logic [8:0]       chunk_size;
  logic [OFF_W-1:0] off_step;
  logic [15:0]      bytes_dec;
  logic [8:0]       chunk_dec;
  logic [23:0]      addr_inc;
  logic [1:0]       addr_idx_inc;
  logic [7:0]       addr_sel;

  // handshake control
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;
  assign advance  = s1_valid_r && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (out_free) begin
        out_valid_r <= advance;
      end
    end
  end

  // reciprocal multiply for the page offset
  assign recip_prod = in_address * RECIP;

  // input register
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_kind_r       <= in_kind;
      s1_operation_r  <= in_operation;
      s1_address_r    <= in_address;
      s1_length_r     <= in_length;
      s1_miso_byte_r  <= in_miso_byte;
      s1_write_byte_r <= in_write_byte;
      s1_quot_r       <= recip_prod[32 +: Q_W];
    end
  end

  // remainder with one correction step
  assign quot_base = {{(24 - Q_W){1'b0}}, s1_quot_r} * PAGE24;
  assign rem_raw   = s1_address_r - quot_base;
  assign rem_lo    = rem_raw[OFF_W:0];
  always_comb begin
    if (rem_lo >= PAGE_REM) begin
      req_off = OFF_W'(rem_lo - PAGE_REM);
    end else begin
      req_off = rem_lo[OFF_W-1:0];
    end
  end

  // chunk size for a new chunk, from the request or from the running state
  assign chunk_off   = (s1_kind_r == KIND_REQ) ? req_off : page_off_r;
  assign chunk_bytes = (s1_kind_r == KIND_REQ) ? s1_length_r : bytes_rem_r;
  assign room        = PAGE9 - 9'(chunk_off);
  assign chunk_size  = (chunk_bytes < 16'(room)) ? 9'(chunk_bytes) : room;

  // counters stepping by one byte
  assign off_step     = ((next_addr_r == ADDR_MAX) || (page_off_r == OFF_LAST)) ?
                        '0 : OFF_W'(page_off_r + 1'b1);
  assign bytes_dec    = 16'(bytes_rem_r - 16'd1);
  assign chunk_dec    = 9'(chunk_rem_r - 9'd1);
  assign addr_inc     = 24'(next_addr_r + 24'd1);
  assign addr_idx_inc = 2'(addr_idx_r + 2'd1);

  // next address byte, most significant first
  always_comb begin
    case (addr_idx_inc)
      2'd0:    addr_sel = next_addr_r[23:16];
      2'd1:    addr_sel = next_addr_r[15:8];
      2'd2:    addr_sel = next_addr_r[7:0];
      default: addr_sel = 8'h00;
    endcase
  end

  // phase logic: one pass per item
  always_comb begin
    phase_nxt     = phase_r;
    cur_op_nxt    = cur_op_r;
    next_addr_nxt = next_addr_r;
    bytes_rem_nxt = bytes_rem_r;
    chunk_rem_nxt = chunk_rem_r;
    addr_idx_nxt  = addr_idx_r;
    page_off_nxt  = page_off_r;
    res_nxt       = '0;

    unique case (s1_kind_r)
      KIND_REQ: begin
        if ((phase_r != PH_IDLE) || (s1_operation_r == OP_INVALID)) begin
          res_nxt.rejected = 1'b1;
        end else begin
          cur_op_nxt    = s1_operation_r;
          next_addr_nxt = s1_address_r;
          page_off_nxt  = req_off;
          bytes_rem_nxt = s1_length_r;
          chunk_rem_nxt = '0;
          addr_idx_nxt  = '0;
          unique case (s1_operation_r) inside
            OP_READ: begin
              phase_nxt         = PH_OPC;
              res_nxt.send      = 1'b1;
              res_nxt.mosi_byte = CMD_READ;
            end
            OP_WRITE: begin
              if (s1_length_r == 16'd0) begin
                phase_nxt        = PH_IDLE;
                res_nxt.done_res = 1'b1;
              end else begin
                chunk_rem_nxt     = chunk_size;
                phase_nxt         = PH_WREN;
                res_nxt.send      = 1'b1;
                res_nxt.mosi_byte = CMD_WREN;
                res_nxt.end_frame = 1'b1;
              end
            end
            OP_SECTOR, OP_BULK: begin
              phase_nxt         = PH_WREN;
              res_nxt.send      = 1'b1;
              res_nxt.mosi_byte = CMD_WREN;
              res_nxt.end_frame = 1'b1;
            end
            OP_READ_ID: begin
              phase_nxt         = PH_ID_OP;
              res_nxt.send      = 1'b1;
              res_nxt.mosi_byte = CMD_ID;
            end
            OP_PDOWN: begin
              phase_nxt         = PH_STAT_OP;
              res_nxt.send      = 1'b1;
              res_nxt.mosi_byte = CMD_STATUS;
            end
            OP_RELEASE: begin
              phase_nxt         = PH_FINAL;
              res_nxt.send      = 1'b1;
              res_nxt.mosi_byte = CMD_WAKE;
              res_nxt.end_frame = 1'b1;
            end
            default: begin
              res_nxt.rejected = 1'b1;
            end
          endcase
        end
      end

      KIND_DONE: begin
        unique case (phase_r) inside
          PH_WREN: begin
            res_nxt.send = 1'b1;
            if (cur_op_r == OP_WRITE) begin
              phase_nxt         = PH_OPC;
              res_nxt.mosi_byte = CMD_PROGRAM;
            end else if (cur_op_r == OP_SECTOR) begin
              phase_nxt         = PH_OPC;
              res_nxt.mosi_byte = CMD_SECTOR;
            end else begin
              phase_nxt         = PH_ERASE_SENT;
              res_nxt.mosi_byte = CMD_BULK;
              res_nxt.end_frame = 1'b1;
            end
          end
          PH_ERASE_SENT: begin
            phase_nxt         = PH_STAT_OP;
            res_nxt.send      = 1'b1;
            res_nxt.mosi_byte = CMD_STATUS;
          end
          PH_OPC: begin
            addr_idx_nxt      = '0;
            phase_nxt         = PH_ADDR;
            res_nxt.send      = 1'b1;
            res_nxt.mosi_byte = next_addr_r[23:16];
          end
          PH_ADDR: begin
            if (addr_idx_r < ADDR_IDX_LAST) begin
              addr_idx_nxt      = addr_idx_inc;
              res_nxt.send      = 1'b1;
              res_nxt.mosi_byte = addr_sel;
              res_nxt.end_frame = (addr_idx_inc == ADDR_IDX_LAST) &&
                                  ((cur_op_r == OP_SECTOR) ||
                                   ((cur_op_r == OP_READ) && (bytes_rem_r == 16'd0)));
            end else if (cur_op_r == OP_READ) begin
              if (bytes_rem_r == 16'd0) begin
                phase_nxt        = PH_IDLE;
                res_nxt.done_res = 1'b1;
              end else begin
                phase_nxt         = PH_READ_SENT;
                res_nxt.send      = 1'b1;
                res_nxt.mosi_byte = FILLER;
                res_nxt.end_frame = (bytes_rem_r == 16'd1);
              end
            end else if (cur_op_r == OP_SECTOR) begin
              phase_nxt         = PH_STAT_OP;
              res_nxt.send      = 1'b1;
              res_nxt.mosi_byte = CMD_STATUS;
            end else begin
              phase_nxt         = PH_DATA_WAIT;
              res_nxt.need_data = 1'b1;
            end
          end
          PH_DATA_SENT: begin
            chunk_rem_nxt = chunk_dec;
            bytes_rem_nxt = bytes_dec;
            next_addr_nxt = addr_inc;
            page_off_nxt  = off_step;
            if (chunk_dec != 9'd0) begin
              phase_nxt         = PH_DATA_WAIT;
              res_nxt.need_data = 1'b1;
            end else begin
              phase_nxt         = PH_STAT_OP;
              res_nxt.send      = 1'b1;
              res_nxt.mosi_byte = CMD_STATUS;
            end
          end
          PH_READ_SENT: begin
            bytes_rem_nxt      = bytes_dec;
            next_addr_nxt      = addr_inc;
            page_off_nxt       = off_step;
            res_nxt.read_valid = 1'b1;
            res_nxt.read_byte  = s1_miso_byte_r;
            if (bytes_dec == 16'd0) begin
              phase_nxt        = PH_IDLE;
              res_nxt.done_res = 1'b1;
            end else begin
              res_nxt.send      = 1'b1;
              res_nxt.mosi_byte = FILLER;
              res_nxt.end_frame = (bytes_dec == 16'd1);
            end
          end
          PH_STAT_OP: begin
            phase_nxt         = PH_POLL;
            res_nxt.send      = 1'b1;
            res_nxt.mosi_byte = FILLER;
          end
          PH_POLL: begin
            if (s1_miso_byte_r[BUSY_BIT]) begin
              res_nxt.send      = 1'b1;
              res_nxt.mosi_byte = FILLER;
            end else if ((cur_op_r == OP_WRITE) && (bytes_rem_r != 16'd0)) begin
              chunk_rem_nxt     = chunk_size;
              phase_nxt         = PH_WREN;
              res_nxt.send      = 1'b1;
              res_nxt.mosi_byte = CMD_WREN;
              res_nxt.end_frame = 1'b1;
            end else if (cur_op_r == OP_PDOWN) begin
              phase_nxt         = PH_FINAL;
              res_nxt.send      = 1'b1;
              res_nxt.mosi_byte = CMD_SLEEP;
              res_nxt.end_frame = 1'b1;
            end else begin
              phase_nxt        = PH_IDLE;
              res_nxt.done_res = 1'b1;
            end
          end
          PH_ID_OP: begin
            addr_idx_nxt      = '0;
            phase_nxt         = PH_ID_SENT;
            res_nxt.send      = 1'b1;
            res_nxt.mosi_byte = FILLER;
          end
          PH_ID_SENT: begin
            res_nxt.read_valid = 1'b1;
            res_nxt.read_byte  = s1_miso_byte_r;
            if (addr_idx_r < ADDR_IDX_LAST) begin
              addr_idx_nxt      = addr_idx_inc;
              res_nxt.send      = 1'b1;
              res_nxt.mosi_byte = FILLER;
              res_nxt.end_frame = (addr_idx_inc == ADDR_IDX_LAST);
            end else begin
              phase_nxt        = PH_IDLE;
              res_nxt.done_res = 1'b1;
            end
          end
          PH_FINAL: begin
            phase_nxt        = PH_IDLE;
            res_nxt.done_res = 1'b1;
          end
          PH_IDLE, PH_DATA_WAIT: begin
            res_nxt.rejected = 1'b1;
          end
          default: begin
            phase_nxt        = PH_IDLE;
            res_nxt.rejected = 1'b1;
          end
        endcase
      end

      KIND_DATA: begin
        if (phase_r != PH_DATA_WAIT) begin
          res_nxt.rejected = 1'b1;
        end else begin
          phase_nxt         = PH_DATA_SENT;
          res_nxt.send      = 1'b1;
          res_nxt.mosi_byte = s1_write_byte_r;
          res_nxt.end_frame = (chunk_rem_r == 9'd1);
        end
      end

      default: begin
        res_nxt.rejected = 1'b1;
      end
    endcase
  end

  // sequencer state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      cur_op_r    <= '0;
      next_addr_r <= '0;
      bytes_rem_r <= '0;
      chunk_rem_r <= '0;
      addr_idx_r  <= '0;
      page_off_r  <= '0;
    end else if (advance) begin
      phase_r     <= phase_nxt;
      cur_op_r    <= cur_op_nxt;
      next_addr_r <= next_addr_nxt;
      bytes_rem_r <= bytes_rem_nxt;
      chunk_rem_r <= chunk_rem_nxt;
      addr_idx_r  <= addr_idx_nxt;
      page_off_r  <= page_off_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_send       = out_res_r.send;
  assign out_mosi_byte  = out_res_r.mosi_byte;
  assign out_end_frame  = out_res_r.end_frame;
  assign out_need_data  = out_res_r.need_data;
  assign out_read_valid = out_res_r.read_valid;
  assign out_read_byte  = out_res_r.read_byte;
  assign out_done_res   = out_res_r.done_res;
  assign out_rejected   = out_res_r.rejected;

`ifndef SYNTHESIS
  // tracked page offset follows the address
  a_page_off: assert property (@(posedge clk) disable iff (!rst_n)
    32'(page_off_r) == (32'(next_addr_r) % PAGE_SIZE))
    else $error("page offset out of step with address");

  // a chunk never spans more than one page
  a_chunk_max: assert property (@(posedge clk) disable iff (!rst_n)
    32'(chunk_rem_r) <= PAGE_SIZE)
    else $error("chunk larger than a page");

  // a waiting-for-data result leaves the sequencer waiting for data
  a_need_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.need_data) |-> (phase_r == PH_DATA_WAIT))
    else $error("need_data without data wait phase");

  // a finished request leaves the sequencer idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.done_res) |-> (phase_r == PH_IDLE))
    else $error("done without idle phase");

  // a rejected item causes no transfer, data request or completion
  a_rej_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.rejected) |->
      (!out_res_r.send && !out_res_r.need_data && !out_res_r.read_valid &&
       !out_res_r.done_res))
    else $error("rejected item with side effects");
`endif

endmodule
